// ----- rtl/esam_pkg.sv -----
package esam_pkg;

  // Fixed-point format of the data path.
  localparam int FRAC_BITS = 16;

  // Exponent argument: limited to +/-64.0, so it fits in FRAC_BITS + 8 signed bits.
  localparam int XW = FRAC_BITS + 8;
  // Exponent times log2(e) in signed Q10.46 (FRAC_BITS + 30 fraction bits).
  localparam int TW = XW + 32;
  // Integer part of the base-2 exponent.
  localparam int KW = TW - FRAC_BITS - 30;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  localparam logic [30:0] STEP_MAX  = 31'h7FFF_FFFF;

  localparam logic signed [XW-1:0] XMAX = XW'(64 << FRAC_BITS);
  localparam logic signed [XW-1:0] XMIN = -XW'(64 << FRAC_BITS);

  // Taylor series terms after the linear one.
  localparam int TERM_FIRST = 2;
  localparam int TERM_LAST  = 12;
  localparam int NTERMS     = TERM_LAST - TERM_FIRST + 1;

  // Exact division by n for 30-bit dividends: (a * RECIP[n]) >> RSHIFT[n].
  localparam logic [30:0] RECIP [TERM_FIRST:TERM_LAST] = '{
    31'd1073741824, 31'd1431655766, 31'd1073741824, 31'd1717986919,
    31'd1431655766, 31'd1227133514, 31'd1073741824, 31'd1908874354,
    31'd1717986919, 31'd1561806290, 31'd1431655766
  };
  localparam int RSHIFT [TERM_FIRST:TERM_LAST] = '{
    31, 32, 32, 33, 33, 33, 33, 34, 34, 34, 34
  };

  // Configuration register indexes.
  localparam logic [1:0] REG_TAU_LOCAL    = 2'd0;
  localparam logic [1:0] REG_TAU_GLOBAL   = 2'd1;
  localparam logic [1:0] REG_MIN_STRATEGY = 2'd2;

  // Clamp codes.
  localparam logic [1:0] CLAMP_NONE  = 2'd0;
  localparam logic [1:0] CLAMP_UPPER = 2'd1;
  localparam logic [1:0] CLAMP_LOWER = 2'd2;

  // Fields that ride along the pipeline with each request.
  typedef struct packed {
    logic signed [31:0]   value;
    logic [30:0]          step;
    logic signed [31:0]   local_s;
    logic signed [31:0]   upper;
    logic signed [31:0]   lower;
    logic signed [KW-1:0] k;
    logic                 sat;
  } side_t;

endpackage

// ----- rtl/es_self_adaptive_mutation_top.sv -----
// Self-adaptive log-normal mutation of one evolution-strategy vector element
// per request, in signed Q16.16 fixed point.
// Input channel s_*: tdata carries value_in, step_in, local_sample,
// global_sample, upper_limit and lower_limit. Output channel m_*: tdata carries
// value_out, step_out, clamp_code and saturated. Each input request gives
// exactly one result.
// Configuration channel cfg_*: index 0 tau_local, 1 tau_global,
// 2 min_strategy; other indexes are ignored. cfg_ready is always high.
// One request is taken every cycle while the output is not stalled. In the
// exp unit, each of the eleven higher Taylor terms takes a multiply stage
// and a reciprocal divide stage.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the default rates
// (tau_local 23170, tau_global 11585, min_strategy 655).
module es_self_adaptive_mutation_top
  import esam_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] value_in, [62:32] step_in, [94:63] local_sample,
  // [126:95] global_sample, [158:127] upper_limit, [190:159] lower_limit
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] value_out, [62:32] step_out, [64:63] clamp_code, [65] saturated
  output logic [71:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  logic [15:0] tau_local;
  logic [15:0] tau_global;
  logic [30:0] min_strategy;

  logic en;

  // Stage registers.
  logic                   v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11;
  side_t                  sd1, sd2, sd3, sd4, sd5, sd6, sd7, sd8, sd9, sd10;
  logic signed [48:0]     pg1, pl1;
  logic signed [XW-1:0]   x2;
  logic signed [TW-1:0]   t3;
  logic [29:0]            u4;
  logic [30:0]            e5;
  logic [61:0]            p6;
  logic [61:0]            r7;
  logic                   big7;
  logic [30:0]            ns8, ns9, ns10, ns11;
  logic signed [63:0]     prod9;
  logic signed [31:0]     vs10;
  logic signed [31:0]     vo11;
  logic [1:0]             code11;
  logic                   sat11;

  // Taylor chain registers: A stage multiplies by u, B stage divides by n.
  logic        va  [NTERMS];
  logic        vb  [NTERMS];
  side_t       sda [NTERMS];
  side_t       sdb [NTERMS];
  logic [29:0] ua  [NTERMS];
  logic [29:0] ub  [NTERMS];
  logic [30:0] ea  [NTERMS];
  logic [30:0] eb  [NTERMS];
  logic [29:0] aa  [NTERMS];
  logic [29:0] tb  [NTERMS];

  // Combinational helpers.
  side_t                sd_in;
  side_t                sd2_next, sd4_next, sd8_next, sd10_next;
  logic signed [49:0]   xsum;
  logic signed [33:0]   xs;
  logic signed [XW-1:0] x_next;
  logic                 xsat;
  logic signed [KW-1:0] k_next;
  logic [59:0]          uprod;
  logic signed [KW:0]   sh;
  logic [61:0]          r_next;
  logic                 big_next;
  logic [30:0]          ns_next;
  logic signed [48:0]   vsum;
  logic signed [31:0]   vs_next;
  logic                 vsat;
  logic signed [31:0]   vo_next;
  logic [1:0]           code_next;

  // The whole pipeline advances unless a result waits at the output.
  assign en        = !v11 || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tau_local    <= 16'd23170;
      tau_global   <= 16'd11585;
      min_strategy <= 31'd655;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TAU_LOCAL:    tau_local    <= cfg_data[15:0];
        REG_TAU_GLOBAL:   tau_global   <= cfg_data[15:0];
        REG_MIN_STRATEGY: min_strategy <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the request.
  always_comb begin
    sd_in.value   = s_tdata[31:0];
    sd_in.step    = s_tdata[62:32];
    sd_in.local_s = s_tdata[94:63];
    sd_in.upper   = s_tdata[158:127];
    sd_in.lower   = s_tdata[190:159];
    sd_in.k       = '0;
    sd_in.sat     = 1'b0;
  end

  // Exponent argument, limited to +/-64.0.
  always_comb begin
    xsum = 50'(pg1) + 50'(pl1);
    xs   = 34'(xsum >>> 16);
    xsat = 1'b0;
    if (xs > 34'(XMAX)) begin
      x_next = XMAX;
      xsat   = 1'b1;
    end else if (xs < 34'(XMIN)) begin
      x_next = XMIN;
    end else begin
      x_next = XW'(xs);
    end
  end

  // Split into integer power of two and fraction times ln2.
  always_comb begin
    k_next = KW'(t3 >>> (FRAC_BITS + 30));
    uprod  = 60'(t3[FRAC_BITS+29:FRAC_BITS]) * 60'(LN2_Q30);
  end

  // Scale by 2^k with saturation.
  always_comb begin
    sh = (KW+1)'(30) - {sd6.k[KW-1], sd6.k};
    if (sd6.k >= KW'(31)) begin
      r_next   = '0;
      big_next = (p6 != '0);
    end else begin
      r_next   = (sh >= (KW+1)'(64)) ? '0 : (p6 >> sh[5:0]);
      big_next = (r_next > 62'(STEP_MAX));
    end
  end

  // Step saturation to STEP_MAX and floor at min_strategy.
  always_comb begin
    ns_next = big7 ? STEP_MAX : r7[30:0];
    if (ns_next < min_strategy) ns_next = min_strategy;
  end

  // Value update with saturation to 32 bits.
  always_comb begin
    vsum = 49'(sd9.value) + 49'(prod9 >>> FRAC_BITS);
    vsat = 1'b0;
    if (vsum > 49'sh0_7FFF_FFFF) begin
      vs_next = 32'sh7FFF_FFFF;
      vsat    = 1'b1;
    end else if (vsum < -49'sh0_8000_0000) begin
      vs_next = -32'sh8000_0000;
      vsat    = 1'b1;
    end else begin
      vs_next = 32'(vsum);
    end
  end

  // Bounds: upper first, then lower.
  always_comb begin
    vo_next   = vs10;
    code_next = CLAMP_NONE;
    if (vo_next > sd10.upper) begin
      vo_next   = sd10.upper;
      code_next = CLAMP_UPPER;
    end
    if (vo_next < sd10.lower) begin
      vo_next   = sd10.lower;
      code_next = CLAMP_LOWER;
    end
  end

  // Side fields with the flags and the shift of each stage merged in.
  always_comb begin
    sd2_next      = sd1;
    sd2_next.sat  = xsat;
    sd4_next      = sd3;
    sd4_next.k    = k_next;
    sd8_next      = sd7;
    sd8_next.sat  = sd7.sat | big7;
    sd10_next     = sd9;
    sd10_next.sat = sd9.sat | vsat;
  end

  // Valid bits of the fixed stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
      v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0;
    end else if (en) begin
      v1  <= s_tvalid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= vb[NTERMS-1];
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
      v11 <= v10;
    end
  end

  // Payload of the fixed stages.
  always_ff @(posedge clk) begin
    if (en) begin
      sd1 <= sd_in;
      pg1 <= $signed({1'b0, tau_global}) * $signed(s_tdata[126:95]);
      pl1 <= $signed({1'b0, tau_local}) * $signed(s_tdata[94:63]);

      sd2 <= sd2_next;
      x2  <= x_next;

      sd3 <= sd2;
      t3  <= x2 * $signed({1'b0, LOG2E_Q30});

      sd4 <= sd4_next;
      u4  <= uprod[59:30];

      sd5 <= sdb[NTERMS-1];
      e5  <= eb[NTERMS-1] + 31'(tb[NTERMS-1]);

      sd6 <= sd5;
      p6  <= 62'(sd5.step) * 62'(e5);

      sd7  <= sd6;
      r7   <= r_next;
      big7 <= big_next;

      sd8 <= sd8_next;
      ns8 <= ns_next;

      sd9   <= sd8;
      ns9   <= ns8;
      prod9 <= $signed({1'b0, ns8}) * sd8.local_s;

      sd10 <= sd10_next;
      ns10 <= ns9;
      vs10 <= vs_next;

      vo11   <= vo_next;
      code11 <= code_next;
      sat11  <= sd10.sat;
      ns11   <= ns10;
    end
  end

  // Taylor series of exp(u), two stages per term.
  for (genvar j = 0; j < NTERMS; j++) begin : g_term
    logic [29:0] term_in;
    logic [30:0] e_in;
    logic [29:0] u_in;
    side_t       sd_src;
    logic        v_src;
    logic [59:0] mprod;
    logic [60:0] dprod;

    if (j == 0) begin : g_first
      assign term_in = u4;
      assign e_in    = ONE_Q30;
      assign u_in    = u4;
      assign sd_src  = sd4;
      assign v_src   = v4;
    end else begin : g_next
      assign term_in = tb[j-1];
      assign e_in    = eb[j-1];
      assign u_in    = ub[j-1];
      assign sd_src  = sdb[j-1];
      assign v_src   = vb[j-1];
    end

    assign mprod = 60'(term_in) * 60'(u_in);
    assign dprod = 61'(aa[j]) * 61'(RECIP[j+TERM_FIRST]);

    always_ff @(posedge clk) begin
      if (rst) begin
        va[j] <= 1'b0;
        vb[j] <= 1'b0;
      end else if (en) begin
        va[j] <= v_src;
        vb[j] <= va[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sda[j] <= sd_src;
        ua[j]  <= u_in;
        ea[j]  <= e_in + 31'(term_in);
        aa[j]  <= mprod[59:30];
        sdb[j] <= sda[j];
        ub[j]  <= ua[j];
        eb[j]  <= ea[j];
        tb[j]  <= 30'(dprod >> RSHIFT[j+TERM_FIRST]);
      end
    end
  end

  // Output register.
  assign m_tvalid = v11;
  assign m_tdata  = {6'd0, sat11, code11, ns11, vo11};

endmodule
